@@ hw/rtl/tcd_pkg.sv @@
package tcd_pkg;

  localparam int unsigned CfgWidth    = 16;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned NowWidth    = 32;
  localparam int unsigned CountWidth  = 8;
  localparam int unsigned SpanWidth   = 32;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_DEBOUNCE_MS  = 2'd0,
    CFG_WINDOW_MS    = 2'd1,
    CFG_CLICK_MAX_MS = 2'd2
  } cfg_idx_e;

  localparam logic [CfgWidth-1:0] DebounceReset = 16'd50;
  localparam logic [CfgWidth-1:0] WindowReset   = 16'd2000;
  localparam logic [CfgWidth-1:0] ClickMaxReset = 16'd1000;

  localparam logic [CountWidth-1:0] TripleClicks = 8'd3;
  localparam logic [CountWidth-1:0] TallyMax     = 8'd255;

  typedef struct packed {
    logic                raw_level;
    logic [NowWidth-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic                  pressed;
    logic                  triple_click;
    logic [CountWidth-1:0] captured_count;
    logic [SpanWidth-1:0]  captured_span_ms;
  } out_item_t;

endpackage

@@ hw/rtl/tcd_if.sv @@
interface tcd_in_if;
  import tcd_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface tcd_out_if;
  import tcd_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ hw/rtl/tcd_in_stage.sv @@
module tcd_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  tcd_pkg::in_item_t item_i,
  input  logic              adv_i,
  output logic              valid_o,
  output tcd_pkg::in_item_t item_o
);
  import tcd_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;

  assign ready_o = !valid_q || adv_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ hw/rtl/tcd_core.sv @@
module tcd_core #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tcd_pkg::CfgIdxWidth-1:0]     cfg_index_i,
  input  logic [tcd_pkg::CfgWidth-1:0]        cfg_data_i,
  input  logic                                step_i,
  input  tcd_pkg::in_item_t                   item_i,
  output tcd_pkg::out_item_t                  result_o
);
  import tcd_pkg::*;

  localparam int unsigned TW = TIME_WIDTH;

  logic [CfgWidth-1:0] debounce_q, window_q, click_max_q;

  logic                  stable_q, stable_d;
  logic                  prev_raw_q, prev_raw_d;
  logic [TW-1:0]         bounce_q, bounce_d;
  logic [CountWidth-1:0] tally_q, tally_d;
  logic [TW-1:0]         seq_start_q, seq_start_d;
  logic [TW-1:0]         press_start_q, press_start_d;
  logic [CountWidth-1:0] held_count_q, held_count_d;
  logic [TW-1:0]         held_span_q, held_span_d;

  logic [TW-1:0] now, bounce_dt, seq_dt, press_dt;
  logic          raw, raw_change, settled, level_flip;
  logic          press, release_ev, expired, held_long, detect;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q  <= DebounceReset;
      window_q    <= WindowReset;
      click_max_q <= ClickMaxReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DEBOUNCE_MS:  debounce_q  <= cfg_data_i;
        CFG_WINDOW_MS:    window_q    <= cfg_data_i;
        CFG_CLICK_MAX_MS: click_max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign raw       = item_i.raw_level;
  assign now       = item_i.now_ms[TW-1:0];
  assign bounce_dt = now - bounce_q;
  assign seq_dt    = now - seq_start_q;
  assign press_dt  = now - press_start_q;

  assign raw_change = raw != prev_raw_q;
  assign settled    = bounce_dt >= TW'(debounce_q);
  assign level_flip = !raw_change && settled && (raw != stable_q);
  assign press      = level_flip && !raw;
  assign release_ev = level_flip && raw;
  assign expired    = seq_dt > TW'(window_q);
  assign held_long  = press_dt > TW'(click_max_q);
  assign detect     = release_ev && !held_long && (tally_q >= TripleClicks) && !expired;

  always_comb begin
    stable_d      = stable_q;
    prev_raw_d    = raw;
    bounce_d      = raw_change ? now : bounce_q;
    tally_d       = tally_q;
    seq_start_d   = seq_start_q;
    press_start_d = press_start_q;
    held_count_d  = held_count_q;
    held_span_d   = held_span_q;

    if (level_flip) begin
      stable_d = raw;
    end
    if (press) begin
      press_start_d = now;
      if (tally_q == '0 || expired) begin
        tally_d     = 8'd1;
        seq_start_d = now;
      end else if (tally_q != TallyMax) begin
        tally_d = tally_q + 8'd1;
      end
    end
    if (release_ev) begin
      if (held_long) begin
        tally_d = '0;
      end else if (detect) begin
        held_count_d = tally_q;
        held_span_d  = seq_dt;
        tally_d      = '0;
        seq_start_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q      <= 1'b1;
      prev_raw_q    <= 1'b1;
      bounce_q      <= '0;
      tally_q       <= '0;
      seq_start_q   <= '0;
      press_start_q <= '0;
      held_count_q  <= '0;
      held_span_q   <= '0;
    end else if (step_i) begin
      stable_q      <= stable_d;
      prev_raw_q    <= prev_raw_d;
      bounce_q      <= bounce_d;
      tally_q       <= tally_d;
      seq_start_q   <= seq_start_d;
      press_start_q <= press_start_d;
      held_count_q  <= held_count_d;
      held_span_q   <= held_span_d;
    end
  end

  assign result_o.pressed          = !stable_d;
  assign result_o.triple_click     = detect;
  assign result_o.captured_count   = held_count_d;
  assign result_o.captured_span_ms = SpanWidth'(held_span_d);

endmodule

@@ hw/rtl/tcd_out_stage.sv @@
module tcd_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  tcd_pkg::out_item_t result_i,
  output logic               adv_o,
  output logic               valid_o,
  input  logic               ready_i,
  output tcd_pkg::out_item_t result_o
);
  import tcd_pkg::*;

  logic      valid_q, valid_d;
  out_item_t result_q;

  // free when empty or when the held item leaves this cycle
  assign adv_o   = !valid_q || ready_i;
  assign valid_d = adv_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && valid_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

@@ hw/rtl/triple_click_detector_unit.sv @@
// Debounced active-low button with a triple-click detector. Each item is one
// poll (raw level, millisecond timestamp); each item gives exactly one result
// carrying the debounced state, a one-item detection pulse and the count and
// span captured at the last detection. One item per cycle is sustained while
// the result side is not stalled: an input register feeds a single pass of
// subtract-and-compare logic on the state registers, and a result register holds
// the output, so an item passes the input register and then the result register.
// A stalled result holds the input register, and a full input register holds the
// input side. The user is to write configuration through the plain write port
// while no item is in flight; the block itself does not enforce this.
module triple_click_detector_unit #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tcd_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input  logic [tcd_pkg::CfgWidth-1:0]    cfg_data_i,
  tcd_in_if.sink                          item_i,
  tcd_out_if.source                       result_o
);
  import tcd_pkg::*;

  logic      stage_valid, adv, step;
  in_item_t  stage_item;
  out_item_t core_result;

  tcd_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (item_i.valid),
    .ready_o (item_i.ready),
    .item_i  (item_i.payload),
    .adv_i   (adv),
    .valid_o (stage_valid),
    .item_o  (stage_item)
  );

  assign step = stage_valid && adv;

  tcd_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (step),
    .item_i      (stage_item),
    .result_o    (core_result)
  );

  tcd_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (stage_valid),
    .result_i (core_result),
    .adv_o    (adv),
    .valid_o  (result_o.valid),
    .ready_i  (result_o.ready),
    .result_o (result_o.payload)
  );

endmodule

@@ hw/rtl/tcd_checker.sv @@
module tcd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input tcd_pkg::out_item_t out_item_i
);
  import tcd_pkg::*;

  // a detection is raised only on a debounced release
  a_detect_on_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_item_i.triple_click |-> !out_item_i.pressed)
    else $error("detection reported while pressed");

  a_detect_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_item_i.triple_click |-> out_item_i.captured_count >= TripleClicks)
    else $error("detection with fewer than three clicks");

  // an empty result register always frees the input side
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with no result pending");

  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_item_i))
    else $error("stalled result changed");

endmodule

bind triple_click_detector_unit tcd_checker u_tcd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (item_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_item_i  (result_o.payload)
);

@@ test/tb_triple_click_detector_unit.sv @@
module tb_triple_click_detector_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import tcd_pkg::*;

  localparam int unsigned ClkPeriod   = 20;
  localparam int unsigned ResetCycles = 4;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned RandomPolls = 200;
  localparam int unsigned PhasePolls  = 50;
  localparam int unsigned SatClicks   = 255;

  localparam logic [CfgIdxWidth-1:0] CfgIdxSpare = 2'd3;

  typedef enum int {
    ReadyAlways,
    ReadyHalf,
    ReadySparse
  } ready_mode_e;

  // Tracks the debounced level, the open click sequence and the last capture.
  class click_tracker;
    logic [CfgWidth-1:0]   deb_ms;
    logic [CfgWidth-1:0]   win_ms;
    logic [CfgWidth-1:0]   max_click_ms;
    logic                  settled_lvl;
    logic                  last_raw;
    logic [NowWidth-1:0]   change_stamp;
    logic [NowWidth-1:0]   seq_origin;
    logic [NowWidth-1:0]   press_origin;
    logic [CountWidth-1:0] tally;
    logic [CountWidth-1:0] cap_count;
    logic [SpanWidth-1:0]  cap_span;
    out_item_t             expected_reports[$];
    int unsigned           errors;

    function new();
      deb_ms       = DebounceReset;
      win_ms       = WindowReset;
      max_click_ms = ClickMaxReset;
      settled_lvl  = 1'b1;
      last_raw     = 1'b1;
      change_stamp = '0;
      seq_origin   = '0;
      press_origin = '0;
      tally        = '0;
      cap_count    = '0;
      cap_span     = '0;
      errors       = 0;
    endfunction

    function void apply_config(logic [CfgIdxWidth-1:0] idx, logic [CfgWidth-1:0] data);
      case (idx)
        CFG_DEBOUNCE_MS:  deb_ms = data;
        CFG_WINDOW_MS:    win_ms = data;
        CFG_CLICK_MAX_MS: max_click_ms = data;
        default: ;
      endcase
    endfunction

    function out_item_t predict(in_item_t poll);
      out_item_t           res;
      logic [NowWidth-1:0] t;
      logic                pulse;
      t     = poll.now_ms;
      pulse = 1'b0;
      if (poll.raw_level !== last_raw) begin
        // restart the debounce timer
        change_stamp = t;
        last_raw     = poll.raw_level;
      end else if (((t - change_stamp) >= deb_ms) && (poll.raw_level !== settled_lvl)) begin
        settled_lvl = poll.raw_level;
        if (!settled_lvl) begin
          press_origin = t;
          if ((tally == '0) || ((t - seq_origin) > win_ms)) begin
            tally      = 8'd1;
            seq_origin = t;
          end else if (tally != TallyMax) begin
            tally++;
          end
        end else if ((t - press_origin) > max_click_ms) begin
          // held too long to count as a click
          tally = '0;
        end else if ((tally >= TripleClicks) && ((t - seq_origin) <= win_ms)) begin
          cap_count  = tally;
          cap_span   = t - seq_origin;
          tally      = '0;
          seq_origin = '0;
          pulse      = 1'b1;
        end
      end
      res.pressed          = ~settled_lvl;
      res.triple_click     = pulse;
      res.captured_count   = cap_count;
      res.captured_span_ms = cap_span;
      return res;
    endfunction

    function void note_poll(in_item_t poll);
      expected_reports.push_back(predict(poll));
    endfunction

    function int unsigned pending();
      return expected_reports.size();
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      if (errors <= 50) begin
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      end
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (expected_reports.size() == 0) begin
        report_mismatch("result with nothing pending, span", got.captured_span_ms, '0);
        return;
      end
      want = expected_reports.pop_front();
      if (got.pressed !== want.pressed)
        report_mismatch("pressed", 32'(got.pressed), 32'(want.pressed));
      if (got.triple_click !== want.triple_click)
        report_mismatch("triple_click", 32'(got.triple_click), 32'(want.triple_click));
      if (got.captured_count !== want.captured_count)
        report_mismatch("captured_count", 32'(got.captured_count),
                        32'(want.captured_count));
      if (got.captured_span_ms !== want.captured_span_ms)
        report_mismatch("captured_span_ms", got.captured_span_ms, want.captured_span_ms);
    endtask
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxWidth-1:0] cfg_index_i;
  logic [CfgWidth-1:0]    cfg_data_i;

  tcd_in_if  item_if ();
  tcd_out_if result_if ();

  triple_click_detector_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (item_if),
    .result_o   (result_if)
  );

  click_tracker        tracker = new();
  int unsigned         burst_left = 0;
  int unsigned         polls_sent = 0;
  logic [NowWidth-1:0] clock_ms;
  ready_mode_e         ready_mode = ReadyAlways;
  int unsigned         mode_left = 0;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // receiver stall pattern: switch between modes after a run of random length
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      ready_mode = ready_mode_e'($urandom_range(0, 2));
      mode_left  = $urandom_range(40, 300);
    end
    mode_left--;
    case (ready_mode)
      ReadyAlways: result_if.ready <= 1'b1;
      ReadyHalf:   result_if.ready <= 1'($urandom_range(0, 1));
      default:     result_if.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && item_if.valid && item_if.ready) tracker.note_poll(item_if.payload);
    if (rst_ni && result_if.valid && result_if.ready) tracker.check_result(result_if.payload);
  end

  task automatic send_poll(input logic lvl, input logic [NowWidth-1:0] stamp);
    in_item_t poll;
    if (burst_left == 0) begin
      item_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    poll.raw_level = lvl;
    poll.now_ms    = stamp;
    item_if.valid   <= 1'b1;
    item_if.payload <= poll;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    burst_left--;
    polls_sent++;
  endtask

  task automatic drain();
    item_if.valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CfgIdxWidth-1:0] idx, input logic [CfgWidth-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    tracker.apply_config(idx, data);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_all(input logic [CfgWidth-1:0] deb, input logic [CfgWidth-1:0] win,
                         input logic [CfgWidth-1:0] cmax);
    write_cfg(CFG_DEBOUNCE_MS, deb);
    write_cfg(CFG_WINDOW_MS, win);
    write_cfg(CFG_CLICK_MAX_MS, cmax);
  endtask

  task automatic configure_phase(input int unsigned phase);
    int unsigned deb;
    int unsigned cmax;
    int unsigned lo;
    int unsigned hi;
    case (phase)
      0: set_all('0, '1, '1);
      1: set_all('1, '1, '0);
      default: begin
        if ($urandom_range(0, 3) == 0) begin
          set_all(CfgWidth'($urandom_range(0, 65535)), CfgWidth'($urandom_range(0, 65535)),
                  CfgWidth'($urandom_range(0, 65535)));
        end else begin
          // keep the window wide enough for a few clicks to fit
          deb  = $urandom_range(0, 120);
          cmax = $urandom_range(0, 1500);
          hi   = 8 * (deb + cmax) + 100;
          if (hi > 65535) hi = 65535;
          lo = 2 * (deb + cmax);
          if (lo > hi) lo = hi;
          set_all(CfgWidth'(deb), CfgWidth'($urandom_range(lo, hi)), CfgWidth'(cmax));
        end
      end
    endcase
    if (phase == 2) write_cfg(CfgIdxSpare, CfgWidth'($urandom_range(0, 65535)));
  endtask

  task automatic hold_level(input logic lvl, input int unsigned dur);
    int unsigned n;
    int unsigned step;
    n    = $urandom_range(2, 4);
    step = dur / (n - 1);
    clock_ms += $urandom_range(0, 3);
    send_poll(lvl, clock_ms);
    repeat (n - 1) begin
      clock_ms += step + $urandom_range(0, 2);
      send_poll(lvl, clock_ms);
    end
  endtask

  task automatic bounce(input logic lvl);
    int unsigned span;
    span = tracker.deb_ms / 2 + 1;
    repeat ($urandom_range(0, 3)) begin
      clock_ms += $urandom_range(0, span);
      send_poll(lvl, clock_ms);
      clock_ms += $urandom_range(0, span);
      send_poll(~lvl, clock_ms);
    end
  endtask

  task automatic click_once();
    int unsigned deb;
    int unsigned cmax;
    int unsigned press_len;
    deb  = 32'(tracker.deb_ms);
    cmax = 32'(tracker.max_click_ms);
    if ($urandom_range(0, 7) == 0) press_len = cmax + $urandom_range(1, 300);
    else press_len = $urandom_range(0, cmax);
    bounce(1'b0);
    hold_level(1'b0, (press_len > deb) ? press_len : deb);
    bounce(1'b1);
    hold_level(1'b1, deb + $urandom_range(0, tracker.win_ms / 4 + 1));
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 8)) begin
      if ($urandom_range(0, 4) == 0) clock_ms = $urandom();
      else clock_ms += $urandom_range(0, tracker.deb_ms + 1);
      send_poll(1'($urandom_range(0, 1)), clock_ms);
    end
  endtask

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("triple_click_detector_unit regression: fail");
    $finish;
  end

  initial begin : stimulus
    int unsigned         phase;
    int unsigned         rand_start;
    int unsigned         phase_start;
    logic [NowWidth-1:0] d;
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_index_i     <= CFG_DEBOUNCE_MS;
    cfg_data_i      <= '0;
    item_if.valid   <= 1'b0;
    item_if.payload <= '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: time extremes, a triple click across the wrap, a long press, a bounce
    d = NowWidth'(DebounceReset);
    send_poll(1'b1, '0);
    send_poll(1'b1, '1);
    clock_ms = 32'hFFFF_FF00;
    repeat (3) begin
      send_poll(1'b0, clock_ms);
      send_poll(1'b0, clock_ms + d);
      send_poll(1'b1, clock_ms + 2 * d);
      send_poll(1'b1, clock_ms + 3 * d);
      clock_ms += 4 * d;
    end
    send_poll(1'b0, clock_ms);
    send_poll(1'b0, clock_ms + d);
    send_poll(1'b1, clock_ms + d + ClickMaxReset + 100);
    send_poll(1'b1, clock_ms + 2 * d + ClickMaxReset + 100);
    clock_ms += 2 * d + ClickMaxReset + 200;
    send_poll(1'b0, clock_ms);
    send_poll(1'b1, clock_ms + 10);
    send_poll(1'b0, clock_ms + 20);
    send_poll(1'b0, clock_ms + 20 + d);
    send_poll(1'b1, clock_ms + 30 + d);
    send_poll(1'b1, clock_ms + 30 + 2 * d);

    // saturate the tally: zero window lets every press at the origin extend the sequence
    drain();
    set_all('0, '0, '1);
    clock_ms = $urandom();
    repeat (SatClicks) begin
      send_poll(1'b0, clock_ms);
      send_poll(1'b0, clock_ms);
      send_poll(1'b1, clock_ms + 1);
      send_poll(1'b1, clock_ms + 1);
    end
    send_poll(1'b0, clock_ms);
    send_poll(1'b0, clock_ms);
    send_poll(1'b1, clock_ms);
    send_poll(1'b1, clock_ms);

    phase      = 0;
    rand_start = polls_sent;
    clock_ms   = $urandom();
    while (polls_sent - rand_start < RandomPolls) begin
      drain();
      configure_phase(phase);
      phase_start = polls_sent;
      while (polls_sent - phase_start < PhasePolls) begin
        if ($urandom_range(0, 9) < 7) begin
          repeat ($urandom_range(1, 5)) click_once();
          // let the window run out now and then
          if ($urandom_range(0, 2) == 0) hold_level(1'b1, tracker.win_ms + $urandom_range(1, 500));
        end else begin
          noise_burst();
        end
      end
      phase++;
    end

    drain();
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("triple_click_detector_unit regression: pass");
    end else begin
      $display("triple_click_detector_unit regression: fail");
    end
    $finish;
  end

endmodule

@@ triple_click_detector_unit.f @@
hw/rtl/tcd_pkg.sv
hw/rtl/tcd_if.sv
hw/rtl/tcd_in_stage.sv
hw/rtl/tcd_core.sv
hw/rtl/tcd_out_stage.sv
hw/rtl/triple_click_detector_unit.sv
hw/rtl/tcd_checker.sv
test/tb_triple_click_detector_unit.sv
